// ===== sv/pse_pkg.sv =====
`timescale 1ns / 1ps

package pse_pkg;

	// Store depth and output capacity register
	localparam int MAX_LEN = 32;
	localparam int CAP_W = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd64;

	// Character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_TOP    = 8'h80;

	// Slots an escape sequence uses
	localparam logic [CAP_W-1:0] ESC_COST = 11'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_TERM
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;   // store incoming byte
		logic start;  // begin emitting stored string
		logic rd;     // read store at walk index
		logic emit;   // load chunk into output register
		logic term;   // load terminator, clear string state
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic more;      // another byte to emit and budget left
		logic out_free;  // output register can take an item
	} stat_t;

endpackage

// ===== sv/pse_if.sv =====
`timescale 1ns / 1ps

// Source byte channel
interface pse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       has_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output has_byte, output end_of_string,
		input ready);
	modport sink (input valid, input in_byte, input has_byte, input end_of_string,
		output ready);
endinterface

// Result channel
interface pse_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_chars;
	logic [2:0]  out_count;
	logic        string_done;
	logic        input_overflow;

	modport source (output valid, output out_chars, output out_count, output string_done,
		output input_overflow, input ready);
	modport sink (input valid, input out_chars, input out_count, input string_done,
		input input_overflow, output ready);
endinterface

// Capacity register write channel
interface pse_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pse_pkg::CAP_W-1:0]    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pse_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module pse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/pse_ctrl.sv =====
`timescale 1ns / 1ps

module pse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_end,
	output logic           in_ready,
	output pse_pkg::cmd_t  cmd,
	input  pse_pkg::stat_t stat
);

	pse_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			pse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_end) begin
						cmd.start = 1'b1;
						state_d   = pse_pkg::ST_READ;
					end
				end
			end
			pse_pkg::ST_READ: begin
				if (stat.more) begin
					cmd.rd  = 1'b1;
					state_d = pse_pkg::ST_EMIT;
				end else begin
					state_d = pse_pkg::ST_TERM;
				end
			end
			pse_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = pse_pkg::ST_READ;
				end
			end
			pse_pkg::ST_TERM: begin
				if (stat.out_free) begin
					cmd.term = 1'b1;
					state_d  = pse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pse_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/pse_dp.sv =====
`timescale 1ns / 1ps

module pse_dp #(
	parameter int MAX_LEN = pse_pkg::MAX_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                in_byte,
	input  logic                      has_byte,
	input  logic                      cap_we,
	input  logic [pse_pkg::CAP_W-1:0] cap_wdata,
	input  pse_pkg::cmd_t             cmd,
	output pse_pkg::stat_t            stat,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [31:0]               out_chars,
	output logic [2:0]                out_count,
	output logic                      string_done,
	output logic                      input_overflow
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	logic [CW-1:0]             stored_count_q, trim_len_q, idx_q;
	logic                      past_q, ovf_q;
	logic [pse_pkg::CAP_W-1:0] cap_q, remain_q;
	logic                      keep, store_we, full;
	logic [7:0]                rd_data;
	logic                      out_valid_q;
	logic [31:0]               out_chars_q;
	logic [2:0]                out_count_q;
	logic                      out_done_q, out_ovf_q;
	logic [31:0]               chunk_chars;
	logic [2:0]                chunk_cnt;
	logic [pse_pkg::CAP_W-1:0] chunk_cost;
	logic                      printable;

	// Byte intake: drop leading spaces, flag bytes past the store
	assign keep     = cmd.take && has_byte && (past_q || (in_byte != pse_pkg::CH_SPACE));
	assign full     = (stored_count_q == CW'(MAX_LEN));
	assign store_we = keep && !full;

	pse_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(stored_count_q[AW-1:0]),
		.wdata(in_byte),
		.re   (cmd.rd),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	// String state; trim_len tracks the end of the last non-space, non-zero byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			trim_len_q     <= '0;
			past_q         <= 1'b0;
			ovf_q          <= 1'b0;
			idx_q          <= '0;
			remain_q       <= '0;
			cap_q          <= pse_pkg::CAP_RESET;
		end else begin
			if (cap_we) begin
				cap_q <= cap_wdata;
			end
			if (keep) begin
				past_q <= 1'b1;
				if (full) begin
					ovf_q <= 1'b1;
				end
			end
			if (store_we) begin
				stored_count_q <= stored_count_q + CW'(1);
				if (in_byte != pse_pkg::CH_SPACE && in_byte != pse_pkg::CH_NUL) begin
					trim_len_q <= stored_count_q + CW'(1);
				end
			end
			if (cmd.start) begin
				idx_q    <= '0;
				remain_q <= cap_q;
			end
			if (cmd.emit) begin
				idx_q    <= idx_q + CW'(1);
				remain_q <= remain_q - chunk_cost;
			end
			if (cmd.term) begin
				stored_count_q <= '0;
				trim_len_q     <= '0;
				past_q         <= 1'b0;
				ovf_q          <= 1'b0;
			end
		end
	end

	// Chunk for the byte just read
	assign printable = (rd_data >= pse_pkg::CH_SPACE) && (rd_data < pse_pkg::CH_TOP);

	always_comb begin
		if (printable) begin
			chunk_chars = {24'd0, rd_data};
			chunk_cnt   = 3'd1;
			chunk_cost  = pse_pkg::CAP_W'(1);
		end else if (remain_q > pse_pkg::ESC_COST) begin
			chunk_chars = {pse_pkg::CH_ZERO + {5'd0, rd_data[2:0]},
				pse_pkg::CH_ZERO + {5'd0, rd_data[5:3]},
				pse_pkg::CH_ZERO + {6'd0, rd_data[7:6]},
				pse_pkg::CH_BSLASH};
			chunk_cnt   = 3'd4;
			chunk_cost  = pse_pkg::ESC_COST;
		end else begin
			chunk_chars = {24'd0, pse_pkg::CH_QMARK};
			chunk_cnt   = 3'd1;
			chunk_cost  = pse_pkg::CAP_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_chars_q <= chunk_chars;
			out_count_q <= chunk_cnt;
			out_done_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else if (cmd.term) begin
			out_chars_q <= '0;
			out_count_q <= '0;
			out_done_q  <= 1'b1;
			out_ovf_q   <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_chars      = out_chars_q;
	assign out_count      = out_count_q;
	assign string_done    = out_done_q;
	assign input_overflow = out_ovf_q;

	assign stat.more     = (idx_q < trim_len_q) && (remain_q > pse_pkg::CAP_W'(1));
	assign stat.out_free = !out_valid_q || out_ready;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= CW'(MAX_LEN))
		else $error("stored count beyond store depth");

	a_trim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		trim_len_q <= stored_count_q)
		else $error("trimmed length beyond stored count");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.term |=> (stored_count_q == '0) && !ovf_q && !past_q && out_valid_q)
		else $error("terminator did not clear string state");

	a_emit_budget: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (remain_q > pse_pkg::CAP_W'(1)) && (chunk_cost <= remain_q))
		else $error("chunk emitted beyond output capacity");
`endif

endmodule

// ===== sv/printable_string_escaper.sv =====
`timescale 1ns / 1ps

// Sanitizes an identification string for display.
// byte_ch: one source byte per item (has_byte qualifies in_byte, end_of_string
//   closes the string). Leading spaces are dropped; bytes past MAX_LEN are
//   dropped and reported on the terminator.
// result_ch: one item per kept byte up to the last non-blank, non-NUL one while budget
//   lasts (the byte itself, a backslash and three octal digits, or '?' near the end of
//   the budget), then a terminator item with string_done set and the overflow flag.
// cfg_ch: writes out_capacity (buffer size including the terminator); always
//   ready; the user must write it only while the block is idle (not enforced here).
// Timing: bytes without the end mark are taken one per cycle. After the end
//   item the block walks the store: for each result one state issues the
//   registered store read, the next loads the output register once it is free;
//   after the last chunk (or at once for an end item that yields no chunk) a
//   last state loads the terminator. byte_ch is not ready during the walk.
// Stalls: a held result waits in the output register; the walk resumes as
//   soon as the receiver takes it.
// Reset: string counters clear, out_capacity returns to 64; store contents are
//   undefined but never read before being written.
module printable_string_escaper #(
	parameter int MAX_LEN = pse_pkg::MAX_LEN
) (
	input logic       clk,
	input logic       arst_n,
	pse_in_if.sink    byte_ch,
	pse_out_if.source result_ch,
	pse_cfg_if.sink   cfg_ch
);

	pse_pkg::cmd_t  cmd;
	pse_pkg::stat_t stat;

	assign cfg_ch.ready = 1'b1;

	pse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(byte_ch.valid),
		.in_end  (byte_ch.end_of_string),
		.in_ready(byte_ch.ready),
		.cmd     (cmd),
		.stat    (stat)
	);

	pse_dp #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_byte       (byte_ch.in_byte),
		.has_byte      (byte_ch.has_byte),
		.cap_we        (cfg_ch.valid),
		.cap_wdata     (cfg_ch.data),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (result_ch.ready),
		.out_valid     (result_ch.valid),
		.out_chars     (result_ch.out_chars),
		.out_count     (result_ch.out_count),
		.string_done   (result_ch.string_done),
		.input_overflow(result_ch.input_overflow)
	);

endmodule

// ===== tb/escape_checker.sv =====
`timescale 1ns / 1ps

// Watches the byte, result and capacity channels, predicts the escaped
// output of each finished string and compares it with what the block sends.
module escape_checker (
	input  logic clk,
	input  logic arst_n,
	pse_in_if    byte_ch,
	pse_out_if   result_ch,
	pse_cfg_if   cfg_ch,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [31:0] chars;
		logic [2:0]  count;
		logic        done;
		logic        ovf;
	} chunk_t;

	chunk_t                    expected_chunks[$];
	logic [7:0]                kept_bytes [pse_pkg::MAX_LEN];
	int                        kept_len = 0;
	logic                      past_lead = 1'b0;
	logic                      dropped = 1'b0;
	logic [pse_pkg::CAP_W-1:0] capacity = pse_pkg::CAP_RESET;
	int                        mismatches = 0;

	task automatic queue_chunk(input logic [31:0] chars, input logic [2:0] count,
		input logic done, input logic ovf);
		chunk_t c;
		c.chars = chars;
		c.count = count;
		c.done  = done;
		c.ovf   = ovf;
		expected_chunks.push_back(c);
	endtask

	// Fold one accepted source item into the string; an end item emits it
	task automatic absorb_source_item(input logic [7:0] b, input logic has,
		input logic eos);
		int         len;
		int         remain;
		int         i;
		logic [7:0] c;
		// leading blanks never reach the store
		if (has && (past_lead || b != pse_pkg::CH_SPACE)) begin
			past_lead = 1'b1;
			if (kept_len < pse_pkg::MAX_LEN) begin
				kept_bytes[kept_len] = b;
				kept_len++;
			end else begin
				dropped = 1'b1;
			end
		end
		if (eos) begin
			len = kept_len;
			// trailing blanks and NULs are not shown
			while (len > 0 && (kept_bytes[len-1] == pse_pkg::CH_SPACE ||
				kept_bytes[len-1] == pse_pkg::CH_NUL))
				len--;
			remain = capacity;
			for (i = 0; i < len && remain > 1; i++) begin
				c = kept_bytes[i];
				if (c >= pse_pkg::CH_SPACE && c < pse_pkg::CH_TOP) begin
					queue_chunk({24'd0, c}, 3'd1, 1'b0, 1'b0);
					remain--;
				end else if (remain > pse_pkg::ESC_COST) begin
					// backslash, then octal digits high to low
					queue_chunk({pse_pkg::CH_ZERO + {5'd0, c[2:0]},
						pse_pkg::CH_ZERO + {5'd0, c[5:3]},
						pse_pkg::CH_ZERO + {6'd0, c[7:6]}, pse_pkg::CH_BSLASH},
						3'd4, 1'b0, 1'b0);
					remain -= pse_pkg::ESC_COST;
				end else begin
					queue_chunk({24'd0, pse_pkg::CH_QMARK}, 3'd1, 1'b0, 1'b0);
					remain--;
				end
			end
			queue_chunk(32'd0, 3'd0, 1'b1, dropped);
			kept_len  = 0;
			past_lead = 1'b0;
			dropped   = 1'b0;
		end
	endtask

	// Compare one accepted result with the oldest prediction
	task automatic check_result();
		chunk_t want;
		logic   bad;
		if (expected_chunks.size() == 0) begin
			$display("%0t: unexpected result chars=%h count=%0d done=%b ovf=%b", $time,
				result_ch.out_chars, result_ch.out_count, result_ch.string_done,
				result_ch.input_overflow);
			mismatches++;
		end else begin
			want = expected_chunks.pop_front();
			bad = 1'b0;
			if (result_ch.out_chars !== want.chars) begin
				$display("%0t: out_chars expected %h actual %h", $time, want.chars,
					result_ch.out_chars);
				bad = 1'b1;
			end
			if (result_ch.out_count !== want.count) begin
				$display("%0t: out_count expected %0d actual %0d", $time, want.count,
					result_ch.out_count);
				bad = 1'b1;
			end
			if (result_ch.string_done !== want.done) begin
				$display("%0t: string_done expected %b actual %b", $time, want.done,
					result_ch.string_done);
				bad = 1'b1;
			end
			if (result_ch.input_overflow !== want.ovf) begin
				$display("%0t: input_overflow expected %b actual %b", $time, want.ovf,
					result_ch.input_overflow);
				bad = 1'b1;
			end
			if (bad)
				mismatches++;
		end
	endtask

	// Sample all channels at the clock edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chunks.delete();
			kept_len   = 0;
			past_lead  = 1'b0;
			dropped    = 1'b0;
			capacity   = pse_pkg::CAP_RESET;
			fail_count <= mismatches;
			pending    <= 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready)
				capacity = cfg_ch.data;
			if (byte_ch.valid && byte_ch.ready)
				absorb_source_item(byte_ch.in_byte, byte_ch.has_byte, byte_ch.end_of_string);
			if (result_ch.valid && result_ch.ready)
				check_result();
			fail_count <= mismatches;
			pending    <= expected_chunks.size();
		end
	end

endmodule

// ===== tb/printable_string_escaper_tb.sv =====
`timescale 1ns / 1ps

module printable_string_escaper_tb;

	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;

	pse_in_if  byte_ch ();
	pse_out_if result_ch ();
	pse_cfg_if cfg_ch ();

	int fails;
	int pending;
	int send_idle_pct = 13;
	int recv_idle_pct = 48;
	int item_total = 0;
	int string_total = 0;
	int cap_writes = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	printable_string_escaper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	escape_checker escape_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch),
		.cfg_ch     (cfg_ch),
		.fail_count (fails),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (result_ch.valid && result_ch.ready)
				results_seen <= results_seen + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Send one source item, with a random gap in front
	task automatic send_item(input logic [7:0] b, input logic has, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid         <= 1'b1;
		byte_ch.in_byte       <= b;
		byte_ch.has_byte      <= has;
		byte_ch.end_of_string <= eos;
		do @(posedge clk); while (!byte_ch.ready);
		item_total++;
		if (eos)
			string_total++;
	endtask

	// Hold off until every predicted result has come out
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [pse_pkg::CAP_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cap_writes++;
	endtask

	// Mostly printable, with control, high, blank and NUL bytes mixed in
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			6:       pick_byte = 8'($urandom_range(8'h1F, 8'h00));
			7:       pick_byte = 8'($urandom_range(8'hFF, 8'h80));
			8:       pick_byte = pse_pkg::CH_SPACE;
			9:       pick_byte = $urandom_range(1) ? pse_pkg::CH_NUL : 8'h7F;
			default: pick_byte = 8'($urandom_range(8'h7E, 8'h21));
		endcase
	endfunction

	function automatic logic [pse_pkg::CAP_W-1:0] pick_capacity();
		case ($urandom_range(3))
			0:       pick_capacity = 11'($urandom_range(8, 1));
			1:       pick_capacity = 11'($urandom_range(64, 9));
			2:       pick_capacity = 11'($urandom_range(1024, 65));
			default: pick_capacity = $urandom_range(1) ? 11'd1024 : 11'd1;
		endcase
	endfunction

	// One string: optional leading blanks, a body, optional trailing blanks
	task automatic send_random_string();
		int lead;
		int body_len;
		int trail;
		lead     = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
		body_len = ($urandom_range(7) == 0) ? $urandom_range(40, 30) : $urandom_range(14, 0);
		trail    = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
		repeat (lead)
			send_item(pse_pkg::CH_SPACE, 1'b1, 1'b0);
		repeat (body_len) begin
			// now and then an item without a byte
			if ($urandom_range(15) == 0)
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			send_item(pick_byte(), 1'b1, 1'b0);
		end
		repeat (trail)
			send_item($urandom_range(1) ? pse_pkg::CH_SPACE : pse_pkg::CH_NUL, 1'b1, 1'b0);
		if ($urandom_range(1))
			send_item(pick_byte(), 1'b1, 1'b1);
		else
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input int quota,
		input logic [pse_pkg::CAP_W-1:0] first_cap);
		int start;
		int strings;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = item_total;
		strings = 0;
		while (item_total - start < quota) begin
			// new capacity every few strings, block idle
			if (strings % 6 == 0) begin
				wait_drained();
				set_capacity(strings == 0 ? first_cap : pick_capacity());
			end
			send_random_string();
			strings++;
			if ($urandom_range(9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		byte_ch.valid         <= 1'b0;
		byte_ch.in_byte       <= 8'h00;
		byte_ch.has_byte      <= 1'b0;
		byte_ch.end_of_string <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.data           <= pse_pkg::CAP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: blanks, NUL, control and high bytes, DEL, idle item
		set_capacity(pse_pkg::CAP_RESET);
		send_item(pse_pkg::CH_SPACE, 1'b1, 1'b0);
		send_item("A", 1'b1, 1'b0);
		send_item(pse_pkg::CH_NUL, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h1F, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(pse_pkg::CH_SPACE, 1'b1, 1'b0);
		send_item(pse_pkg::CH_NUL, 1'b1, 1'b1);
		// empty string, blanks only, end item carrying the only byte
		send_item(8'hA5, 1'b0, 1'b1);
		send_item(pse_pkg::CH_SPACE, 1'b1, 1'b0);
		send_item(pse_pkg::CH_SPACE, 1'b1, 1'b1);
		send_item("Z", 1'b1, 1'b1);
		// budget runs out: escape, then '?', then stop
		wait_drained();
		set_capacity(11'd7);
		send_item("a", 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h02, 1'b1, 1'b0);
		send_item("b", 1'b1, 1'b1);
		// room for the terminator only, then for one character
		wait_drained();
		set_capacity(11'd1);
		send_item("x", 1'b1, 1'b1);
		wait_drained();
		set_capacity(11'd2);
		send_item("x", 1'b1, 1'b0);
		send_item("y", 1'b1, 1'b1);

		// Random strings under three stall mixes
		run_phase(13, 48, 80, 11'd1024);
		run_phase(48, 13, 80, 11'd5);
		run_phase(0, 0, 80, 11'd1);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d source items in %0d strings over %0d capacity settings,",
			item_total, string_total, cap_writes);
		$display("checked %0d results with blanks, escapes, overflow and tight budgets.",
			results_seen);
		if (pending != 0)
			$display("%0t: %0d predicted results never arrived", $time, pending);
		if (fails == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
